// ===== hw/rtl/first_fit_peer_slot_scheduler_assert.svh =====
// ----------------------------------------------------------------------------
// Peer slot scheduler assertion macros
// Concurrent checks on clk, disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_PEER_SLOT_SCHEDULER_ASSERT_SVH
`define FIRST_FIT_PEER_SLOT_SCHEDULER_ASSERT_SVH

// check cons in the same cycle as ante
`define FFPS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// check cons in the cycle after ante
`define FFPS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/ffps_pkg.sv =====
// ----------------------------------------------------------------------------
// ffps_pkg
// Shared constants and types of the first-fit peer slot scheduler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ffps_pkg;

  localparam int PEER_SLOTS  = 16;
  localparam int PROC_BITS   = 8;
  localparam int SLOT_BITS   = $clog2(PEER_SLOTS);
  localparam int TOTAL_BITS  = PROC_BITS + SLOT_BITS;
  localparam int PCT_BITS    = 7;
  localparam int CPU_FULL    = 100;
  localparam int CORE_MAX    = 4095;
  localparam int PROD_BITS   = PROC_BITS + PCT_BITS;
  localparam int RECIP       = (2 ** PROD_BITS) / CPU_FULL;
  localparam int RECIP_BITS  = PROD_BITS - 6;
  localparam int TOTAL_MAX   = PEER_SLOTS * (2 ** PROC_BITS - 1);

  typedef enum logic [1:0] {
    CMD_ADD      = 2'd0,
    CMD_REMOVE   = 2'd1,
    CMD_SCHEDULE = 2'd2,
    CMD_FREE     = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_BUSY = 2'd2,
    ST_BAD  = 2'd3
  } status_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [3:0]  peer_slot;
    logic [7:0]  proc_count;
    logic [6:0]  cpu_percent;
  } in_word_t;

  typedef struct packed {
    logic [3:0]  slot_out;
    logic        granted;
    status_t     status_code;
    logic [11:0] free_cores;
  } out_word_t;

  typedef struct packed {
    logic                 start;
    logic [PROC_BITS-1:0] procs;
    logic [PCT_BITS-1:0]  pct;
  } lim_req_t;

  typedef struct packed {
    logic                 done;
    logic [PROC_BITS-1:0] limit;
  } lim_rsp_t;

  typedef struct packed {
    logic                 we;
    logic [SLOT_BITS-1:0] idx;
    logic                 valid;
    logic                 avail;
  } flag_upd_t;

  typedef struct packed {
    logic                  free_found;
    logic [SLOT_BITS-1:0]  free_idx;
    logic                  avail_found;
    logic [SLOT_BITS-1:0]  avail_idx;
    logic [PEER_SLOTS-1:0] valid;
  } flag_view_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ffps_ram.sv =====
// ----------------------------------------------------------------------------
// ffps_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ffps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/ffps_limit.sv =====
// ----------------------------------------------------------------------------
// ffps_limit
// Thread limit unit: procs * min(pct, 100) / 100 over three pipeline stages,
// division by reciprocal multiply with one correction step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ffps_limit (
  input  logic               clk,
  input  logic               rst,
  input  ffps_pkg::lim_req_t req,
  output ffps_pkg::lim_rsp_t rsp
);

  import ffps_pkg::*;

  localparam int SCALED_BITS = PROD_BITS + RECIP_BITS;

  logic [PCT_BITS-1:0]    pct_sat;
  logic                   v1;
  logic                   v2;
  logic                   v3;
  logic [PROD_BITS-1:0]   prod;
  logic [PROD_BITS-1:0]   prod2;
  logic [PROC_BITS-1:0]   est;
  logic [PROC_BITS-1:0]   limit;
  logic [SCALED_BITS-1:0] scaled;
  logic [PROD_BITS-1:0]   rem;

  assign pct_sat = (32'(req.pct) > CPU_FULL) ? PCT_BITS'(CPU_FULL) : req.pct;
  assign scaled  = SCALED_BITS'(prod) * SCALED_BITS'(RECIP);
  assign rem     = prod2 - PROD_BITS'(32'(est) * CPU_FULL);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= req.start;
      v2 <= v1;
      v3 <= v2;
    end
    prod  <= PROD_BITS'(req.procs) * PROD_BITS'(pct_sat);
    prod2 <= prod;
    est   <= PROC_BITS'(scaled >> PROD_BITS);
    // estimate is low by at most one
    limit <= est + ((32'(rem) >= CPU_FULL) ? PROC_BITS'(1) : PROC_BITS'(0));
  end

  assign rsp.done  = v3;
  assign rsp.limit = limit;

endmodule

`default_nettype wire

// ===== hw/rtl/ffps_slot_flags.sv =====
// ----------------------------------------------------------------------------
// ffps_slot_flags
// Per-slot valid and free-thread flags with first-fit encoders for the
// lowest empty slot and the lowest slot with a free thread.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ffps_slot_flags (
  input  logic                 clk,
  input  logic                 rst,
  input  ffps_pkg::flag_upd_t  upd,
  output ffps_pkg::flag_view_t view
);

  import ffps_pkg::*;

  logic [PEER_SLOTS-1:0] valid;
  logic [PEER_SLOTS-1:0] avail;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      avail <= '0;
    end else if (upd.we) begin
      valid[upd.idx] <= upd.valid;
      avail[upd.idx] <= upd.avail;
    end
  end

  always_comb begin
    view.valid       = valid;
    view.free_found  = 1'b0;
    view.free_idx    = '0;
    view.avail_found = 1'b0;
    view.avail_idx   = '0;
    for (int i = PEER_SLOTS - 1; i >= 0; i--) begin
      if (!valid[i]) begin
        view.free_found = 1'b1;
        view.free_idx   = SLOT_BITS'(i);
      end
      if (avail[i]) begin
        view.avail_found = 1'b1;
        view.avail_idx   = SLOT_BITS'(i);
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/first_fit_peer_slot_scheduler.sv =====
// ----------------------------------------------------------------------------
// first_fit_peer_slot_scheduler
// Peer table with first-fit job placement. Entry data (processors, thread
// limit, jobs in use) lives in a RAM; valid and free-thread flags and the
// free-core total live in registers.
//
//   port     dir   handshake              payload
//   cmd_*    in    cmd_valid / cmd_ready   ffps_pkg::in_word_t
//   res_*    out   res_valid / res_ready   ffps_pkg::out_word_t
//
// Remove, schedule, free: RAM read on accept, then update; schedule or granted free writes.
// Add: waits in the limit state for the three-stage thread limit unit.
// Table full, no free thread, bad slot: finished in the idle state, no RAM access.
// Reset clears the slot flags and the total at once; no clearing pass.
// A result waits in the output register; the next word is taken meanwhile
// and holds in the done state only if its result finds that register full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module first_fit_peer_slot_scheduler (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  output logic                cmd_ready,
  input  ffps_pkg::in_word_t  cmd_word,
  output logic                res_valid,
  input  logic                res_ready,
  output ffps_pkg::out_word_t res_word
);

  import ffps_pkg::*;

  `include "first_fit_peer_slot_scheduler_assert.svh"

  typedef struct packed {
    logic [PROC_BITS-1:0] processors;
    logic [PROC_BITS-1:0] thread_limit;
    logic [PROC_BITS-1:0] in_use;
  } entry_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LIMIT,
    S_MODIFY,
    S_DONE
  } state_t;

  state_t               state;
  state_t               state_next;
  in_word_t             item;
  in_word_t             item_next;
  logic [SLOT_BITS-1:0] tgt;
  logic [SLOT_BITS-1:0] tgt_next;
  out_word_t            res;
  out_word_t            res_next;
  logic [TOTAL_BITS-1:0] total;
  logic [TOTAL_BITS-1:0] total_next;
  logic [TOTAL_BITS-1:0] diff;
  logic                 res_valid_next;
  logic                 finish;
  logic                 out_free;
  logic                 out_load;

  logic [SLOT_BITS-1:0] in_idx;
  logic                 in_range;
  logic                 slot_ok;

  flag_upd_t            upd;
  flag_view_t           view;
  lim_req_t             lim_req;
  lim_rsp_t             lim_rsp;

  logic                 ram_we;
  entry_t               ram_wdata;
  logic                 ram_re;
  logic [SLOT_BITS-1:0] ram_raddr;
  entry_t               ram_rdata;

  ffps_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(PEER_SLOTS)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(tgt),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  ffps_limit u_limit (
    .clk(clk),
    .rst(rst),
    .req(lim_req),
    .rsp(lim_rsp)
  );

  ffps_slot_flags u_flags (
    .clk (clk),
    .rst (rst),
    .upd (upd),
    .view(view)
  );

  assign in_idx    = SLOT_BITS'(cmd_word.peer_slot);
  assign in_range  = 32'(cmd_word.peer_slot) < PEER_SLOTS;
  assign slot_ok   = in_range && view.valid[in_idx];
  assign cmd_ready = (state == S_IDLE);
  assign out_free  = !res_valid || res_ready;
  assign diff      = TOTAL_BITS'(ram_rdata.processors - ram_rdata.in_use);

  always_comb begin
    state_next    = state;
    item_next     = item;
    tgt_next      = tgt;
    res_next      = res;
    total_next    = total;
    finish        = 1'b0;
    upd           = '0;
    ram_we        = 1'b0;
    ram_wdata     = ram_rdata;
    ram_re        = 1'b0;
    ram_raddr     = in_idx;
    lim_req.start = 1'b0;
    lim_req.procs = PROC_BITS'(cmd_word.proc_count);
    lim_req.pct   = cmd_word.cpu_percent;

    unique case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          item_next            = cmd_word;
          res_next.slot_out    = '0;
          res_next.granted     = 1'b0;
          unique case (cmd_word.cmd)
            CMD_ADD: begin
              if (view.free_found) begin
                tgt_next      = view.free_idx;
                lim_req.start = 1'b1;
                state_next    = S_LIMIT;
              end else begin
                res_next.status_code = ST_FULL;
                finish               = 1'b1;
              end
            end
            CMD_SCHEDULE: begin
              if (view.avail_found) begin
                tgt_next   = view.avail_idx;
                ram_re     = 1'b1;
                ram_raddr  = view.avail_idx;
                state_next = S_MODIFY;
              end else begin
                res_next.status_code = ST_BUSY;
                finish               = 1'b1;
              end
            end
            CMD_REMOVE, CMD_FREE: begin
              if (slot_ok) begin
                tgt_next   = in_idx;
                ram_re     = 1'b1;
                state_next = S_MODIFY;
              end else begin
                res_next.status_code = ST_BAD;
                finish               = 1'b1;
              end
            end
          endcase
        end
      end
      S_LIMIT: begin
        if (lim_rsp.done) begin
          ram_we                 = 1'b1;
          ram_wdata.processors   = PROC_BITS'(item.proc_count);
          ram_wdata.thread_limit = lim_rsp.limit;
          ram_wdata.in_use       = '0;
          upd                    = '{we: 1'b1, idx: tgt, valid: 1'b1,
                                     avail: (lim_rsp.limit != '0)};
          total_next             = total + TOTAL_BITS'(item.proc_count);
          res_next.slot_out      = 4'(tgt);
          res_next.granted       = 1'b1;
          res_next.status_code   = ST_OK;
          finish                 = 1'b1;
        end
      end
      S_MODIFY: begin
        finish               = 1'b1;
        res_next.slot_out    = '0;
        res_next.granted     = 1'b1;
        res_next.status_code = ST_OK;
        unique case (item.cmd)
          CMD_REMOVE: begin
            upd        = '{we: 1'b1, idx: tgt, valid: 1'b0, avail: 1'b0};
            total_next = total - diff;
          end
          CMD_SCHEDULE: begin
            ram_we            = 1'b1;
            ram_wdata.in_use  = ram_rdata.in_use + PROC_BITS'(1);
            upd               = '{we: 1'b1, idx: tgt, valid: 1'b1,
                                  avail: ((ram_rdata.in_use + PROC_BITS'(1))
                                          < ram_rdata.thread_limit)};
            total_next        = total - TOTAL_BITS'(1);
            res_next.slot_out = 4'(tgt);
          end
          CMD_FREE: begin
            if (ram_rdata.in_use == '0) begin
              res_next.granted     = 1'b0;
              res_next.status_code = ST_BAD;
            end else begin
              ram_we           = 1'b1;
              ram_wdata.in_use = ram_rdata.in_use - PROC_BITS'(1);
              upd              = '{we: 1'b1, idx: tgt, valid: 1'b1, avail: 1'b1};
              total_next       = total + TOTAL_BITS'(1);
            end
          end
          CMD_ADD: begin
            res_next.granted     = 1'b0;
            res_next.status_code = ST_BAD;
          end
        endcase
      end
      S_DONE: begin
        finish = 1'b1;
      end
    endcase

    if (finish) begin
      res_next.free_cores = (32'(total_next) > CORE_MAX) ? 12'(CORE_MAX)
                                                         : 12'(total_next);
      state_next          = out_free ? S_IDLE : S_DONE;
    end
    out_load       = finish && out_free;
    res_valid_next = out_load ? 1'b1 : (res_ready ? 1'b0 : res_valid);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      total     <= '0;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      total     <= total_next;
      res_valid <= res_valid_next;
    end
    item <= item_next;
    tgt  <= tgt_next;
    res  <= res_next;
    if (out_load) begin
      res_word <= res_next;
    end
  end

  `FFPS_ASSERT_NOW(a_ram_we_state, ram_we, (state == S_LIMIT || state == S_MODIFY), "RAM write outside update")
  `FFPS_ASSERT_NOW(a_lim_state, lim_rsp.done, (state == S_LIMIT), "thread limit outside add")
  `FFPS_ASSERT_NOW(a_total_bound, 1'b1, (32'(total) <= TOTAL_MAX), "free-core total out of range")
  `FFPS_ASSERT_NOW(a_grant_ok, res_valid, (res_word.granted == (res_word.status_code == ST_OK)), "grant and status disagree")
  `FFPS_ASSERT_NEXT(a_add_marks, (state == S_LIMIT && lim_rsp.done), view.valid[tgt], "added slot not valid")

endmodule

`default_nettype wire
